[hdl/spq_pkg.sv]
// shared types and codes for the stable priority queue
// no dependencies
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_W         = 16;
    localparam int PRIO_W       = 8;
    localparam int ARR_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [ARR_W-1:0]  arr;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry ins;
    } t_cell_ctl;

endpackage

[hdl/spq_cell.sv]
// one slot of the sorted queue: holds an entry and moves it to a neighbour
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  logic      i_prev_ahead,
    input  t_entry    i_prev_entry,
    input  t_entry    i_next_entry,
    output logic      o_ahead,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // stored entry stays ahead of the new one: higher prio, or equal and not later
    assign o_ahead = i_occupied &&
                     ((r_entry.prio > i_ctl.ins.prio) ||
                      ((r_entry.prio == i_ctl.ins.prio) && (r_entry.arr <= i_ctl.ins.arr)));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (o_ahead) begin
                n_entry = r_entry;
            end else if (i_prev_ahead) begin
                n_entry = i_ctl.ins;
            end else begin
                n_entry = i_prev_entry;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[hdl/stable_priority_queue.sv]
// stable priority queue top level: a row of sorting cells plus count and result register
// depends on spq_pkg and spq_cell
//
// Requests arrive on the input channel (i_in_valid / o_in_stall) with i_kind
// selecting enqueue or dequeue; results leave on the output channel
// (o_out_valid / i_out_stall), one result per request, in request order.
// Every cell compares its own entry with the new key in parallel, so an
// enqueue lands in its sorted place and a dequeue shifts the row up by one,
// all cells updating together. A result is valid in the cycle after
// acceptance; throughput is one request per cycle while the receiver takes
// results. The result register is the only buffer: while it holds a result
// that the receiver stalls, o_in_stall is high and no request is taken.
// Entries of equal priority and arrival leave in insertion order.
// Reset empties the queue (count to zero) and drops any held result (valid
// low); cell contents are not cleared, as only occupied cells are ever read.
// Occupancy is reported modulo 32.
module stable_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [ID_W-1:0]     i_proc_id,
    input  logic [PRIO_W-1:0]   i_prio,
    input  logic [ARR_W-1:0]    i_arrival,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_out_id,
    output logic [PRIO_W-1:0]   o_out_prio,
    output logic [OCC_W-1:0]    o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [ID_W-1:0]     r_out_id;
    logic [ID_W-1:0]     n_out_id;
    logic [PRIO_W-1:0]   r_out_prio;
    logic [PRIO_W-1:0]   n_out_prio;
    logic [OCC_W-1:0]    r_occ;
    logic [OCC_W-1:0]    n_occ;

    logic      accept;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;
    logic      ahead [CAPACITY];
    t_entry    entry [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(CAPACITY));
    assign empty      = (r_count == '0);

    assign ctl.enq = accept && (i_kind == KIND_ENQ) && !full;
    assign ctl.deq = accept && (i_kind == KIND_DEQ) && !empty;
    assign ctl.ins = '{id: i_proc_id, prio: i_prio, arr: i_arrival};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   prev_ahead;
        t_entry prev_entry;
        t_entry next_entry;
        if (g == 0) begin : g_head
            assign prev_ahead = 1'b1;
            assign prev_entry = ctl.ins;
        end else begin : g_mid
            assign prev_ahead = ahead[g-1];
            assign prev_entry = entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign next_entry = entry[g];
        end else begin : g_body
            assign next_entry = entry[g+1];
        end
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_prev_ahead(prev_ahead),
            .i_prev_entry(prev_entry),
            .i_next_entry(next_entry),
            .o_ahead     (ahead[g]),
            .o_entry     (entry[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_out_id    = r_out_id;
        n_out_prio  = r_out_prio;
        n_occ       = r_occ;
        if (ctl.enq) begin
            n_count = r_count + CW'(1);
        end else if (ctl.deq) begin
            n_count = r_count - CW'(1);
        end
        if (accept) begin
            n_out_valid = 1'b1;
            n_out_id    = '0;
            n_out_prio  = '0;
            n_occ       = OCC_W'(n_count);
            if (i_kind == KIND_ENQ) begin
                n_status = full ? ST_FULL : ST_ENQ;
            end else if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status   = ST_DEQ;
                n_out_id   = entry[0].id;
                n_out_prio = entry[0].prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_out_id   <= n_out_id;
        r_out_prio <= n_out_prio;
        r_occ      <= n_occ;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_prio  = r_out_prio;
    assign o_occupancy = r_occ;

endmodule

[tb/tb_stable_priority_queue.sv]
// self-checking testbench for stable_priority_queue: directed and random requests
// with bursty input and a patterned output stall, checked against a sorted-list predictor
// depends on spq_pkg and the stable_priority_queue rtl
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 100;
    localparam int TAIL_CYCLES    = 4;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   prio;
        logic [OCC_W-1:0]    occ;
    } t_result;

    class spq_scoreboard;
        t_entry  service_order[$];
        t_result awaited[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        // model the queue for one accepted request and store the result it owes
        function void note_request(logic kind, logic [ID_W-1:0] id,
                                   logic [PRIO_W-1:0] prio, logic [ARR_W-1:0] arr);
            t_result r;
            t_entry  e;
            int      pos;
            r.id   = '0;
            r.prio = '0;
            if (kind == KIND_ENQ) begin
                if (service_order.size() >= CAPACITY_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    // new entry goes behind higher priorities and behind equal keys
                    pos = 0;
                    while (pos < service_order.size() &&
                           (service_order[pos].prio > prio ||
                            (service_order[pos].prio == prio &&
                             service_order[pos].arr <= arr)))
                        pos++;
                    e.id   = id;
                    e.prio = prio;
                    e.arr  = arr;
                    service_order.insert(pos, e);
                    r.status = ST_ENQ;
                end
            end else begin
                if (service_order.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = service_order.pop_front();
                    r.status = ST_DEQ;
                    r.id     = e.id;
                    r.prio   = e.prio;
                end
            end
            r.occ = OCC_W'(service_order.size());
            awaited.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            // keep the log readable if the design is badly broken
            if (mismatches <= REPORT_CAP)
                $display("mismatch: %s", msg);
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                          logic [PRIO_W-1:0] prio, logic [OCC_W-1:0] occ);
            t_result w;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result status %0d with no request outstanding",
                                          status));
            end else begin
                w = awaited.pop_front();
                if (status !== w.status)
                    report_mismatch($sformatf("status got %0d want %0d", status, w.status));
                if (id !== w.id)
                    report_mismatch($sformatf("id got %h want %h", id, w.id));
                if (prio !== w.prio)
                    report_mismatch($sformatf("prio got %h want %h", prio, w.prio));
                if (occ !== w.occ)
                    report_mismatch($sformatf("occupancy got %0d want %0d", occ, w.occ));
            end
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_kind      = KIND_ENQ;
    logic [ID_W-1:0]     i_proc_id   = '0;
    logic [PRIO_W-1:0]   i_prio      = '0;
    logic [ARR_W-1:0]    i_arrival   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_out_id;
    logic [PRIO_W-1:0]   o_out_prio;
    logic [OCC_W-1:0]    o_occupancy;

    spq_scoreboard sb = new();
    int            burst_left  = 0;
    int            stall_mode  = 0;
    int            stall_span  = 0;
    int            idle_cycles = 0;

    stable_priority_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_proc_id  (i_proc_id),
        .i_prio     (i_prio),
        .i_arrival  (i_arrival),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_out_id   (o_out_id),
        .o_out_prio (o_out_prio),
        .o_occupancy(o_occupancy)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // sender runs in bursts; a gap only opens when a burst is used up
    task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio, input logic [ARR_W-1:0] arr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_proc_id  <= id;
        i_prio     <= prio;
        i_arrival  <= arr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(kind, id, prio, arr);
    endtask

    // receiver stall: spans of no stall, light, heavy and alternating
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 120);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 4) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ~i_out_stall;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_out_id, o_out_prio, o_occupancy);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_stable_priority_queue NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [ARR_W-1:0]  arr;
        int                sent;
        int                run;
        int                enq_pct;
        int                tie_heavy;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // dequeue from empty, with junk on the unused fields
        send_request(KIND_DEQ, 16'hffff, 8'hff, 32'hffff_ffff);
        // field extremes and ties of equal priority and arrival
        send_request(KIND_ENQ, 16'h0000, 8'h00, 32'h0000_0000);
        send_request(KIND_ENQ, 16'hffff, 8'hff, 32'hffff_ffff);
        send_request(KIND_ENQ, 16'h1111, 8'hff, 32'h0000_0000);
        send_request(KIND_ENQ, 16'h2222, 8'hff, 32'hffff_ffff);
        send_request(KIND_ENQ, 16'h3333, 8'h00, 32'hffff_ffff);
        send_request(KIND_ENQ, 16'h4444, 8'h80, 32'd100);
        send_request(KIND_ENQ, 16'h4445, 8'h80, 32'd100);
        send_request(KIND_ENQ, 16'h4446, 8'h80, 32'd100);
        send_request(KIND_ENQ, 16'h5555, 8'h80, 32'd99);
        send_request(KIND_ENQ, 16'h6666, 8'h80, 32'd101);
        for (int k = 0; k < CAPACITY_DEF - 10; k++)
            send_request(KIND_ENQ, ID_W'(16'h7000 + k), 8'h7f, ARR_W'(k % 3));
        // queue is full here, so this one is rejected
        send_request(KIND_ENQ, 16'haaaa, 8'hff, 32'h0000_0000);
        for (int k = 0; k < 5; k++)
            send_request(KIND_DEQ, '0, '0, '0);

        // random part: runs that lean towards filling, draining or neither
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            tie_heavy = $urandom_range(0, 1);
            repeat (run) begin
                kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
                id   = ID_W'($urandom);
                if (tie_heavy && $urandom_range(0, 3) != 0) begin
                    // narrow keys so equal priorities and arrivals meet often
                    prio = PRIO_W'($urandom_range(0, 3));
                    arr  = $urandom_range(0, 7);
                end else begin
                    prio = PRIO_W'($urandom);
                    arr  = $urandom;
                end
                send_request(kind, id, prio, arr);
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("tb_stable_priority_queue OK");
        else
            $display("tb_stable_priority_queue NOT OK");
        $finish;
    end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
